FILE: src/rotated_box_corner_points_defines.svh
`ifndef ROTATED_BOX_CORNER_POINTS_DEFINES_SVH
`define ROTATED_BOX_CORNER_POINTS_DEFINES_SVH

`ifndef SYNTHESIS
`define RBCP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RBCP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RBCP_ASSERT(label, clk, rst_n, prop, msg)
`define RBCP_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

FILE: src/rbcp_pkg.sv
package rbcp_pkg;

  localparam int COORD_FRAC_BITS = 4;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int CORDIC_STAGES   = 16;
  localparam int ZQ              = 24;
  localparam int TABLE_LEN       = 24;

  localparam int EDGE_W    = 20;
  localparam int ANGLE_W   = 16;
  localparam int OUT_W     = 17;
  localparam int NUM_COORD = 8;

  localparam int IN_FIELDS_W = 4 * EDGE_W + ANGLE_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((NUM_COORD * OUT_W + 7) / 8) * 8;

  localparam int EXT_W = EDGE_W + 1;
  localparam int ZW    = 28;
  localparam int XW    = 27;
  localparam int PW    = EXT_W + XW;
  localparam int VW    = PW + 2;
  localparam int ZSH   = ZQ - ANGLE_FRAC_BITS;
  localparam int RSH   = COORD_FRAC_BITS + ZQ + 1;
  localparam int MW    = VW - RSH;

  localparam logic signed [ZW-1:0] PI_Q          = 28'sd52707179;
  localparam logic signed [ZW-1:0] NEG_PI_Q      = -28'sd52707179;
  localparam logic signed [ZW-1:0] TWO_PI_Q      = 28'sd105414357;
  localparam logic signed [ZW-1:0] HALF_PI_Q     = 28'sd26353589;
  localparam logic signed [ZW-1:0] NEG_HALF_PI_Q = -28'sd26353589;
  localparam logic signed [XW-1:0] GAIN_Q        = 27'sd10188014;

  localparam logic [VW-1:0] ROUND_HALF = VW'(1) << (RSH - 1);

  localparam logic [MW-1:0] POS_MAG_MAX = MW'((1 << (OUT_W - 1)) - 1);
  localparam logic [MW-1:0] NEG_MAG_MAX = MW'(1 << (OUT_W - 1));
  localparam logic signed [OUT_W-1:0] OUT_MAX = OUT_W'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [OUT_W-1:0] OUT_MIN = OUT_W'(1 << (OUT_W - 1));

  localparam logic signed [ZW-1:0] ATAN_TAB [TABLE_LEN] = '{
    28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
    28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069,
    28'sd65536,    28'sd32768,   28'sd16384,   28'sd8192,
    28'sd4096,     28'sd2048,    28'sd1024,    28'sd512,
    28'sd256,      28'sd128,     28'sd64,      28'sd32,
    28'sd16,       28'sd8,       28'sd4,       28'sd2
  };

  typedef struct packed {
    logic signed [EXT_W-1:0] cx;
    logic signed [EXT_W-1:0] cy;
    logic signed [EXT_W-1:0] dx;
    logic signed [EXT_W-1:0] dy;
    logic                    flip;
  } side_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } rot_t;

endpackage

FILE: src/rbcp_cordic.sv
module rbcp_cordic
  import rbcp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  rot_t                 rot_i,
  input  side_t                side_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output side_t                side_o
);

  logic  vld_q  [CORDIC_STAGES];
  rot_t  rot_q  [CORDIC_STAGES];
  side_t side_q [CORDIC_STAGES];
  logic  rdy    [CORDIC_STAGES];

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
    logic  vld_in;
    rot_t  rot_in;
    side_t side_in;
    logic  rdy_next;
    rot_t  rot_d;

    if (g == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rot_in  = rot_i;
      assign side_in = side_i;
    end else begin : g_rest
      assign vld_in  = vld_q[g-1];
      assign rot_in  = rot_q[g-1];
      assign side_in = side_q[g-1];
    end

    if (g == CORDIC_STAGES - 1) begin : g_last
      assign rdy_next = ready_i;
    end else begin : g_mid
      assign rdy_next = rdy[g+1];
    end

    assign rdy[g] = !vld_q[g] || rdy_next;

    always_comb begin
      if (!rot_in.z[ZW-1]) begin
        rot_d.x = rot_in.x - (rot_in.y >>> g);
        rot_d.y = rot_in.y + (rot_in.x >>> g);
        rot_d.z = rot_in.z - ATAN_TAB[g];
      end else begin
        rot_d.x = rot_in.x + (rot_in.y >>> g);
        rot_d.y = rot_in.y - (rot_in.x >>> g);
        rot_d.z = rot_in.z + ATAN_TAB[g];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (rdy[g]) begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[g] && vld_in) begin
        rot_q[g]  <= rot_d;
        side_q[g] <= side_in;
      end
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = vld_q[CORDIC_STAGES-1];
  assign x_o     = rot_q[CORDIC_STAGES-1].x;
  assign y_o     = rot_q[CORDIC_STAGES-1].y;
  assign side_o  = side_q[CORDIC_STAGES-1];

endmodule

FILE: src/rotated_box_corner_points.sv
// Pipeline: 23 register stages.
// Throughput: one box per cycle when not stalled; one CORDIC micro-rotation per stage.
// Each stage loads while empty or while the next stage moves, so a stall loses nothing.
// Reset: asynchronous, active low; clears every stage valid bit, data registers keep value.
`include "rotated_box_corner_points_defines.svh"

module rotated_box_corner_points
  import rbcp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // edge_left, edge_top, edge_right, edge_bottom, angle
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y, corner3_x, corner3_y
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic signed [EDGE_W-1:0]  l_w, t_w, r_w, b_w;
  logic signed [ANGLE_W-1:0] a_w;
  logic signed [ZW-1:0]      z_in;

  logic                 vld_p1_q;
  logic                 rdy_p1;
  logic signed [ZW-1:0] z_p1_d, z_p1_q;
  side_t                side_p1_d, side_p1_q;

  logic  vld_p2_q;
  logic  rdy_p2;
  rot_t  rot_p2_d, rot_p2_q;
  side_t side_p2_d, side_p2_q;

  logic                 cor_vld, cor_rdy;
  logic signed [XW-1:0] cor_x, cor_y;
  side_t                cor_side;

  logic                 vld_f_q;
  logic                 rdy_f;
  logic signed [XW-1:0] c_f_d, c_f_q, s_f_d, s_f_q;
  side_t                side_f_q;

  logic                    vld_m_q;
  logic                    rdy_m;
  logic signed [PW-1:0]    pa_d, pa_q, pb_d, pb_q, pc_d, pc_q, pd_d, pd_q;
  logic signed [EXT_W-1:0] cx_m_q, cy_m_q;

  logic                 vld_s_q;
  logic                 rdy_s;
  logic signed [VW-1:0] ea, eb, ec, ed, cx2, cy2;
  logic signed [VW-1:0] v_d [NUM_COORD];
  logic signed [VW-1:0] v_q [NUM_COORD];

  logic          vld_r_q;
  logic          rdy_r;
  logic [VW-1:0] abs_w [NUM_COORD];
  logic [MW-1:0] mag_d [NUM_COORD];
  logic [MW-1:0] mag_q [NUM_COORD];
  logic          neg_d [NUM_COORD];
  logic          neg_q [NUM_COORD];

  logic                   vld_o_q;
  logic                   rdy_o;
  logic [OUT_TDATA_W-1:0] out_d, out_q;

  // unpack and reduce the angle into minus pi to pi
  assign l_w  = s_axis_tdata[0 +: EDGE_W];
  assign t_w  = s_axis_tdata[EDGE_W +: EDGE_W];
  assign r_w  = s_axis_tdata[2*EDGE_W +: EDGE_W];
  assign b_w  = s_axis_tdata[3*EDGE_W +: EDGE_W];
  assign a_w  = s_axis_tdata[4*EDGE_W +: ANGLE_W];
  assign z_in = ZW'(a_w) <<< ZSH;

  always_comb begin
    if (z_in > PI_Q) begin
      z_p1_d = z_in - TWO_PI_Q;
    end else if (z_in < NEG_PI_Q) begin
      z_p1_d = z_in + TWO_PI_Q;
    end else begin
      z_p1_d = z_in;
    end
    side_p1_d.cx   = EXT_W'(l_w) + EXT_W'(r_w);
    side_p1_d.cy   = EXT_W'(t_w) + EXT_W'(b_w);
    side_p1_d.dx   = EXT_W'(r_w) - EXT_W'(l_w);
    side_p1_d.dy   = EXT_W'(b_w) - EXT_W'(t_w);
    side_p1_d.flip = 1'b0;
  end

  assign rdy_p1        = !vld_p1_q || rdy_p2;
  assign s_axis_tready = rdy_p1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_p1_q <= 1'b0;
    end else if (rdy_p1) begin
      vld_p1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_p1 && s_axis_tvalid) begin
      z_p1_q    <= z_p1_d;
      side_p1_q <= side_p1_d;
    end
  end

  // fold the angle into minus pi/2 to pi/2
  always_comb begin
    side_p2_d = side_p1_q;
    rot_p2_d.x = GAIN_Q;
    rot_p2_d.y = '0;
    if (z_p1_q > HALF_PI_Q) begin
      rot_p2_d.z     = z_p1_q - PI_Q;
      side_p2_d.flip = 1'b1;
    end else if (z_p1_q < NEG_HALF_PI_Q) begin
      rot_p2_d.z     = z_p1_q + PI_Q;
      side_p2_d.flip = 1'b1;
    end else begin
      rot_p2_d.z     = z_p1_q;
      side_p2_d.flip = 1'b0;
    end
  end

  assign rdy_p2 = !vld_p2_q || cor_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_p2_q <= 1'b0;
    end else if (rdy_p2) begin
      vld_p2_q <= vld_p1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_p2 && vld_p1_q) begin
      rot_p2_q  <= rot_p2_d;
      side_p2_q <= side_p2_d;
    end
  end

  rbcp_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_p2_q),
    .ready_o (cor_rdy),
    .rot_i   (rot_p2_q),
    .side_i  (side_p2_q),
    .valid_o (cor_vld),
    .ready_i (rdy_f),
    .x_o     (cor_x),
    .y_o     (cor_y),
    .side_o  (cor_side)
  );

  // undo the fold
  assign c_f_d = cor_side.flip ? -cor_x : cor_x;
  assign s_f_d = cor_side.flip ? -cor_y : cor_y;
  assign rdy_f = !vld_f_q || rdy_m;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_f_q <= 1'b0;
    end else if (rdy_f) begin
      vld_f_q <= cor_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_f && cor_vld) begin
      c_f_q    <= c_f_d;
      s_f_q    <= s_f_d;
      side_f_q <= cor_side;
    end
  end

  // extents times cos and sin
  assign pa_d  = PW'(side_f_q.dx) * PW'(c_f_q);
  assign pb_d  = PW'(side_f_q.dy) * PW'(s_f_q);
  assign pc_d  = PW'(side_f_q.dx) * PW'(s_f_q);
  assign pd_d  = PW'(side_f_q.dy) * PW'(c_f_q);
  assign rdy_m = !vld_m_q || rdy_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_m_q <= 1'b0;
    end else if (rdy_m) begin
      vld_m_q <= vld_f_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_m && vld_f_q) begin
      pa_q   <= pa_d;
      pb_q   <= pb_d;
      pc_q   <= pc_d;
      pd_q   <= pd_d;
      cx_m_q <= side_f_q.cx;
      cy_m_q <= side_f_q.cy;
    end
  end

  // corner sums at doubled scale
  always_comb begin
    ea     = VW'(pa_q);
    eb     = VW'(pb_q);
    ec     = VW'(pc_q);
    ed     = VW'(pd_q);
    cx2    = VW'(cx_m_q) <<< ZQ;
    cy2    = VW'(cy_m_q) <<< ZQ;
    v_d[0] = cx2 - ea + eb;
    v_d[1] = cy2 - ec - ed;
    v_d[2] = cx2 + ea + eb;
    v_d[3] = cy2 + ec - ed;
    v_d[4] = cx2 + ea - eb;
    v_d[5] = cy2 + ec + ed;
    v_d[6] = cx2 - ea - eb;
    v_d[7] = cy2 - ec + ed;
  end

  assign rdy_s = !vld_s_q || rdy_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_s_q <= 1'b0;
    end else if (rdy_s) begin
      vld_s_q <= vld_m_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_s && vld_m_q) begin
      v_q <= v_d;
    end
  end

  // round half away from zero
  always_comb begin
    for (int i = 0; i < NUM_COORD; i++) begin
      neg_d[i] = v_q[i][VW-1];
      abs_w[i] = (neg_d[i] ? VW'(-v_q[i]) : VW'(v_q[i])) + ROUND_HALF;
      mag_d[i] = MW'(abs_w[i] >> RSH);
    end
  end

  assign rdy_r = !vld_r_q || rdy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_r_q <= 1'b0;
    end else if (rdy_r) begin
      vld_r_q <= vld_s_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_r && vld_s_q) begin
      mag_q <= mag_d;
      neg_q <= neg_d;
    end
  end

  // saturate and pack
  always_comb begin
    out_d = '0;
    for (int i = 0; i < NUM_COORD; i++) begin
      if (!neg_q[i]) begin
        out_d[i*OUT_W +: OUT_W] = (mag_q[i] > POS_MAG_MAX) ? OUT_MAX : OUT_W'(mag_q[i]);
      end else begin
        out_d[i*OUT_W +: OUT_W] = (mag_q[i] > NEG_MAG_MAX) ? OUT_MIN : -OUT_W'(mag_q[i]);
      end
    end
  end

  assign rdy_o = !vld_o_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o_q <= 1'b0;
    end else if (rdy_o) begin
      vld_o_q <= vld_r_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && vld_r_q) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = vld_o_q;
  assign m_axis_tdata  = out_q;

  `RBCP_ASSERT(a_empty_out_takes_input, clk_i, rst_ni,
               !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")
  `RBCP_ASSERT(a_folded_angle, clk_i, rst_ni,
               vld_p2_q |-> (rot_p2_q.z <= HALF_PI_Q && rot_p2_q.z >= NEG_HALF_PI_Q),
               "folded angle out of range")
  `RBCP_ASSERT(a_out_has_source, clk_i, rst_ni,
               $rose(m_axis_tvalid) |-> $past(vld_r_q), "result without a prior stage")
  `RBCP_ASSERT_ALWAYS(a_reset_clears_out, clk_i,
                      !rst_ni |=> !m_axis_tvalid, "output valid during reset")

endmodule
